// File: rtl/core/pce_pkg.sv
// Shared constants and types of the pointwise convolution engine.
package pce_pkg;

  // Storage geometry.
  localparam int unsigned MaxInChannels  = 16;
  localparam int unsigned MaxOutChannels = 16;
  localparam int unsigned ChanW          = $clog2(MaxInChannels);
  localparam int unsigned OutW           = $clog2(MaxOutChannels);
  localparam int unsigned WgtAddrW       = ChanW + OutW;
  localparam int unsigned AccW           = 40;
  localparam int unsigned ProdW          = 32;
  localparam int unsigned DataW          = 16;
  localparam int unsigned FrameCntW      = 12;
  localparam int unsigned FrameRegW      = 13;
  localparam int unsigned ChanRegW       = 5;
  localparam int unsigned FifoCntW       = OutW + 1;

  // Frame size limit.
  localparam logic [FrameRegW-1:0] FrameLimit = 13'd4096;

  // Request kinds carried in tuser.
  localparam logic [1:0] OP_WEIGHT = 2'd0;
  localparam logic [1:0] OP_BIAS   = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_IN_CHANNELS  = 3'd0;
  localparam logic [2:0] REG_OUT_CHANNELS = 3'd1;
  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd2;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd3;
  localparam logic [2:0] REG_STRIDE       = 3'd4;
  localparam logic [2:0] REG_ACT_MIN      = 3'd5;
  localparam logic [2:0] REG_ACT_MAX      = 3'd6;

  // One queued result.
  typedef struct packed {
    logic                    last;
    logic signed [DataW-1:0] value;
    logic [OutW-1:0]         chan;
  } out_item_t;

endpackage

// File: rtl/core/pointwise_conv_engine_unit.sv
// Pointwise (1x1) convolution engine: weight, bias and accumulator memories with a MAC sweep.
// A weight or bias write or a dropped sample leaves the engine ready for the next request. A
// kept sample sweeps all 16 output channels through the shared multiplier behind a registered
// memory read, and no new request is taken until that sweep ends.
// Results enter a 16-entry queue from the write-back stage; requests wait until it
// drains. Reset clears the counters, accumulator valid bits and queue; stores start undefined.
module pointwise_conv_engine_unit
  import pce_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // out_index[3:0], in_index[7:4], value[23:8]
  input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // channel_index[3:0], result_value[19:4], zero[23:20]
  output logic        m_axis_tlast    // last_channel
);

  // Configuration registers.
  logic [ChanRegW-1:0]     in_ch_q, out_ch_q;
  logic [FrameRegW-1:0]    fwidth_q, fheight_q;
  logic [1:0]              stride_q;
  logic signed [DataW-1:0] act_min_q, act_max_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch_q   <= ChanRegW'(1);
      out_ch_q  <= ChanRegW'(1);
      fwidth_q  <= FrameRegW'(1);
      fheight_q <= FrameRegW'(1);
      stride_q  <= 2'd1;
      act_min_q <= 16'sh8000;
      act_max_q <= 16'sh7fff;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_IN_CHANNELS:  in_ch_q   <= cfg_data_i[ChanRegW-1:0];
        REG_OUT_CHANNELS: out_ch_q  <= cfg_data_i[ChanRegW-1:0];
        REG_FRAME_WIDTH:  fwidth_q  <= cfg_data_i[FrameRegW-1:0];
        REG_FRAME_HEIGHT: fheight_q <= cfg_data_i[FrameRegW-1:0];
        REG_STRIDE:       stride_q  <= cfg_data_i[1:0];
        REG_ACT_MIN:      act_min_q <= cfg_data_i;
        REG_ACT_MAX:      act_max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Limited register values, each as the index of its last position.
  logic [ChanRegW-1:0]  nin_lim, nout_lim;
  logic [FrameRegW-1:0] w_lim, h_lim;
  logic [ChanW-1:0]     nin_m1;
  logic [OutW-1:0]      nout_m1;
  logic [FrameCntW-1:0] w_m1, h_m1;

  always_comb begin
    nin_lim  = (in_ch_q == '0) ? ChanRegW'(1) :
               (in_ch_q > ChanRegW'(MaxInChannels)) ? ChanRegW'(MaxInChannels) : in_ch_q;
    nout_lim = (out_ch_q == '0) ? ChanRegW'(1) :
               (out_ch_q > ChanRegW'(MaxOutChannels)) ? ChanRegW'(MaxOutChannels) : out_ch_q;
    w_lim    = (fwidth_q == '0) ? FrameRegW'(1) :
               (fwidth_q > FrameLimit) ? FrameLimit : fwidth_q;
    h_lim    = (fheight_q == '0) ? FrameRegW'(1) :
               (fheight_q > FrameLimit) ? FrameLimit : fheight_q;
    nin_m1   = ChanW'(nin_lim - ChanRegW'(1));
    nout_m1  = OutW'(nout_lim - ChanRegW'(1));
    w_m1     = FrameCntW'(w_lim - FrameRegW'(1));
    h_m1     = FrameCntW'(h_lim - FrameRegW'(1));
  end

  // Request fields.
  logic [1:0]              req_op;
  logic [OutW-1:0]         req_oi;
  logic [ChanW-1:0]        req_ii;
  logic signed [DataW-1:0] req_val;

  assign req_op  = s_axis_tuser;
  assign req_oi  = s_axis_tdata[3:0];
  assign req_ii  = s_axis_tdata[7:4];
  assign req_val = s_axis_tdata[23:8];

  logic in_acc, smp_acc;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign smp_acc = in_acc && (req_op == OP_SAMPLE);

  // Pixel position counters.
  logic [ChanW-1:0]     chan_cnt_q;
  logic [FrameCntW-1:0] col_cnt_q, row_cnt_q;
  logic                 pix_last, pix_kept;

  assign pix_last = (chan_cnt_q >= nin_m1);
  assign pix_kept = (stride_q != 2'd2) || (!row_cnt_q[0] && !col_cnt_q[0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_cnt_q <= '0;
      col_cnt_q  <= '0;
      row_cnt_q  <= '0;
    end else if (smp_acc) begin
      if (pix_last) begin
        chan_cnt_q <= '0;
        if (col_cnt_q >= w_m1) begin
          col_cnt_q <= '0;
          row_cnt_q <= (row_cnt_q >= h_m1) ? '0 : row_cnt_q + FrameCntW'(1);
        end else begin
          col_cnt_q <= col_cnt_q + FrameCntW'(1);
        end
      end else begin
        chan_cnt_q <= chan_cnt_q + ChanW'(1);
      end
    end
  end

  // Sample latched for the sweep.
  logic signed [DataW-1:0] val_q;
  logic [ChanW-1:0]        ch_q;
  logic                    first_q, last_q;
  logic [OutW-1:0]         nout_m1_q;

  always_ff @(posedge clk_i) begin
    if (smp_acc) begin
      val_q     <= req_val;
      ch_q      <= chan_cnt_q;
      first_q   <= (chan_cnt_q == '0);
      last_q    <= pix_last;
      nout_m1_q <= nout_m1;
    end
  end

  // Sweep issue: one output channel per cycle.
  logic            issue_q;
  logic [OutW-1:0] oc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q <= 1'b0;
      oc_q    <= '0;
    end else if (smp_acc && pix_kept) begin
      issue_q <= 1'b1;
      oc_q    <= '0;
    end else if (issue_q) begin
      oc_q <= oc_q + OutW'(1);
      if (oc_q == OutW'(MaxOutChannels - 1)) begin
        issue_q <= 1'b0;
      end
    end
  end

  // Weight and bias memories: written by requests, read during the sweep.
  logic signed [DataW-1:0] wgt_mem [2**WgtAddrW];
  logic signed [DataW-1:0] bias_mem [MaxOutChannels];
  logic signed [DataW-1:0] w_rd_q, b_rd_q;

  always_ff @(posedge clk_i) begin
    if (in_acc && (req_op == OP_WEIGHT)) begin
      wgt_mem[{req_oi, req_ii}] <= req_val;
    end
    w_rd_q <= wgt_mem[{oc_q, ch_q}];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (req_op == OP_BIAS)) begin
      bias_mem[req_oi] <= req_val;
    end
    b_rd_q <= bias_mem[oc_q];
  end

  // Pipeline control.
  logic            s1_vld_q, s2_vld_q, s3_vld_q;
  logic [OutW-1:0] oc1_q, oc2_q, oc3_q;
  logic            use2_q, wr3_q, emit3_q;
  logic [MaxOutChannels-1:0] acc_vld_q;
  logic            avld1_q;

  // Accumulator memory and its datapath registers.
  logic signed [AccW-1:0]  acc_mem [MaxOutChannels];
  logic signed [AccW-1:0]  a_rd_q, base_q, sum_q;
  logic signed [ProdW-1:0] prod_q;
  logic                    use1;

  assign use1 = (oc1_q <= nout_m1_q);

  always_ff @(posedge clk_i) begin
    if (s3_vld_q && wr3_q) begin
      acc_mem[oc3_q] <= sum_q;
    end
    a_rd_q <= acc_mem[oc_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      acc_vld_q <= '0;
    end else begin
      s1_vld_q <= issue_q;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      if (s3_vld_q && wr3_q) begin
        acc_vld_q[oc3_q] <= 1'b1;
      end
    end
  end

  // Stage payloads: multiply, then add, then write back and finish.
  always_ff @(posedge clk_i) begin
    oc1_q   <= oc_q;
    avld1_q <= acc_vld_q[oc_q];
    oc2_q   <= oc1_q;
    use2_q  <= use1;
    prod_q  <= use1 ? ProdW'(val_q * w_rd_q) : '0;
    if (first_q) begin
      base_q <= {{(AccW-DataW-8){b_rd_q[DataW-1]}}, b_rd_q, 8'd0};
    end else begin
      base_q <= avld1_q ? a_rd_q : '0;
    end
    oc3_q   <= oc2_q;
    sum_q   <= base_q + {{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q};
    wr3_q   <= use2_q || first_q;
    emit3_q <= use2_q && last_q;
  end

  // Finish: floor shift by 8, saturate to 16 bits, then clamp.
  logic signed [ProdW-1:0] shifted;
  logic signed [DataW-1:0] sat_val, clamp_val;

  always_comb begin
    shifted = sum_q[AccW-1:8];
    if (!shifted[ProdW-1] && (|shifted[ProdW-2:DataW-1])) begin
      sat_val = 16'sh7fff;
    end else if (shifted[ProdW-1] && !(&shifted[ProdW-2:DataW-1])) begin
      sat_val = 16'sh8000;
    end else begin
      sat_val = shifted[DataW-1:0];
    end
    clamp_val = sat_val;
    if (clamp_val < act_min_q) begin
      clamp_val = act_min_q;
    end
    if (clamp_val > act_max_q) begin
      clamp_val = act_max_q;
    end
  end

  // Result queue.
  out_item_t           fifo_mem [MaxOutChannels];
  logic [OutW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0] fifo_cnt_q;
  logic                push, pop;
  out_item_t           push_item, head_item;

  assign push = s3_vld_q && emit3_q;
  assign pop  = m_axis_tvalid && m_axis_tready;

  always_comb begin
    push_item.last  = (oc3_q == nout_m1_q);
    push_item.value = clamp_val;
    push_item.chan  = oc3_q;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_mem[wr_ptr_q] <= push_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + OutW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + OutW'(1);
      end
      case ({push, pop})
        2'b10:   fifo_cnt_q <= fifo_cnt_q + FifoCntW'(1);
        2'b01:   fifo_cnt_q <= fifo_cnt_q - FifoCntW'(1);
        default: fifo_cnt_q <= fifo_cnt_q;
      endcase
    end
  end

  assign head_item     = fifo_mem[rd_ptr_q];
  assign m_axis_tvalid = (fifo_cnt_q != '0);
  assign m_axis_tdata  = {4'd0, head_item.value, head_item.chan};
  assign m_axis_tlast  = head_item.last;

  // New requests wait for the sweep to end and the queue to drain.
  assign s_axis_tready = !(issue_q || s1_vld_q || s2_vld_q || s3_vld_q) &&
                         (fifo_cnt_q == '0);

endmodule

// File: verif/pointwise_conv_engine_unit_test.sv
// Self-checking testbench for the pointwise convolution engine with a built-in predictor.
`timescale 1ns / 100ps

module pointwise_conv_engine_unit_test
  import pce_pkg::*;
();

  // Request kind that the engine must ignore, and a register index outside the map.
  localparam logic [1:0] OP_IGNORED   = 2'd3;
  localparam logic [2:0] REG_UNUSED   = 3'd7;
  localparam int unsigned NUM_REGS    = 7;
  localparam int unsigned STRIDE_SKIP = 2;
  localparam int unsigned MAX_GAP     = 16;
  localparam int unsigned DRAIN_CYCLES   = 64;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  // Input channels whose weights are loaded; every setting keeps its input count within them.
  localparam int unsigned FILL_IN_CHANNELS = 4;

  typedef struct {
    logic [1:0]  op;
    logic [3:0]  oi;
    logic [3:0]  ii;
    logic [15:0] val;
  } conv_request_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // out_index[3:0], in_index[7:4], value[23:8]
  logic [1:0]  s_axis_tuser = '0;   // opcode[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // channel_index[3:0], result_value[19:4], zero[23:20]
  logic        m_axis_tlast;        // last_channel

  pointwise_conv_engine_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  wire in_fire  = s_axis_tvalid && s_axis_tready;
  wire out_fire = m_axis_tvalid && m_axis_tready;
  wire cfg_fire = cfg_valid_i && cfg_ready_o;

  // Stimulus and expectation stores.
  conv_request_t request_q[$];
  out_item_t     channel_results_q[$];
  conv_request_t in_cur;

  // Predictor state: register mirror, stores, accumulators and raster counters.
  logic [15:0]        reg_mirror [NUM_REGS];
  logic signed [15:0] wgt_mem [256];
  logic signed [15:0] bias_mem [16];
  longint             acc_mem [16];
  int unsigned        chan_cnt, col_cnt, row_cnt;

  int unsigned requests_queued, requests_accepted, results_seen, settings_used;
  int unsigned errors;
  int unsigned in_gap, out_stall, hold_left, idle_cycles;
  logic        no_gaps = 1'b0;
  logic        hold_arm = 1'b0;
  logic        hold_done = 1'b0;

  function automatic logic [15:0] reg_mask(logic [2:0] idx);
    case (idx)
      REG_IN_CHANNELS, REG_OUT_CHANNELS: return 16'h001F;
      REG_FRAME_WIDTH, REG_FRAME_HEIGHT: return 16'h1FFF;
      REG_STRIDE:                        return 16'h0003;
      default:                           return 16'hFFFF;
    endcase
  endfunction

  // Zero behaves as one and oversized values saturate.
  function automatic int unsigned clip_reg(logic [15:0] v, int unsigned top);
    if (v == 0) return 1;
    if (v > top) return top;
    return 32'(v);
  endfunction

  // Floor shift to Q8.8, saturate to 16 bits, then apply the activation clamp.
  function automatic logic signed [15:0] activate(longint acc);
    longint q, lo, hi;
    q  = acc >>> 8;
    lo = longint'($signed(reg_mirror[REG_ACT_MIN]));
    hi = longint'($signed(reg_mirror[REG_ACT_MAX]));
    if (q > 32767) q = 32767;
    else if (q < -32768) q = -32768;
    if (q < lo) q = lo;
    if (q > hi) q = hi;
    return q[15:0];
  endfunction

  // Applies one accepted request and queues the per-channel results it produces.
  function automatic void convolve_request(conv_request_t req);
    int unsigned n_in, n_out, fw, fh;
    bit          kept, last_ch;
    out_item_t   res;
    case (req.op)
      OP_WEIGHT: wgt_mem[{req.oi, req.ii}] = req.val;
      OP_BIAS:   bias_mem[req.oi] = req.val;
      OP_SAMPLE: begin
        n_in  = clip_reg(reg_mirror[REG_IN_CHANNELS], MaxInChannels);
        n_out = clip_reg(reg_mirror[REG_OUT_CHANNELS], MaxOutChannels);
        fw    = clip_reg(reg_mirror[REG_FRAME_WIDTH], 32'(FrameLimit));
        fh    = clip_reg(reg_mirror[REG_FRAME_HEIGHT], 32'(FrameLimit));
        kept  = (reg_mirror[REG_STRIDE] != STRIDE_SKIP) || (row_cnt % 2 == 0 && col_cnt % 2 == 0);
        last_ch = chan_cnt >= n_in - 1;
        if (kept) begin
          if (chan_cnt == 0) begin
            for (int oc = 0; oc < 16; oc++) begin
              acc_mem[4'(oc)] = longint'(bias_mem[4'(oc)]) * 256;
            end
          end
          for (int oc = 0; oc < n_out; oc++) begin
            acc_mem[4'(oc)] += longint'($signed(req.val)) *
                               longint'(wgt_mem[{4'(oc), 4'(chan_cnt)}]);
          end
          if (last_ch) begin
            for (int oc = 0; oc < n_out; oc++) begin
              res.chan  = OutW'(oc);
              res.value = activate(acc_mem[4'(oc)]);
              res.last  = (oc == n_out - 1);
              channel_results_q.push_back(res);
            end
          end
        end
        // Raster advance; counters beyond a shrunken limit wrap on the next pixel end.
        if (last_ch) begin
          chan_cnt = 0;
          if (col_cnt >= fw - 1) begin
            col_cnt = 0;
            if (row_cnt >= fh - 1) row_cnt = 0;
            else row_cnt++;
          end else begin
            col_cnt++;
          end
        end else begin
          chan_cnt++;
        end
      end
      default: ;
    endcase
  endfunction

  // Input driver: offers queued requests with random gaps.
  always @(posedge clk_i) begin : request_driver
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (in_fire) begin
        convolve_request(in_cur);
        requests_accepted++;
        in_gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (!s_axis_tvalid || in_fire) begin
        if (in_gap != 0) begin
          in_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (request_q.size() != 0) begin
          in_cur = request_q.pop_front();
          s_axis_tdata  <= {in_cur.val, in_cur.ii, in_cur.oi};
          s_axis_tuser  <= in_cur.op;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started once when armed.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_arm && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Result monitor: compares each result with the oldest expectation.
  always @(posedge clk_i) begin : result_monitor
    out_item_t got, want;
    if (out_fire) begin
      got.chan  = m_axis_tdata[3:0];
      got.value = m_axis_tdata[19:4];
      got.last  = m_axis_tlast;
      results_seen++;
      if (channel_results_q.size() == 0) begin
        $error("channel_index %0d result_value %0d arrived with nothing expected",
               got.chan, got.value);
        errors++;
      end else begin
        want = channel_results_q.pop_front();
        if (got.chan !== want.chan) begin
          $error("channel_index: expected %0d, got %0d", want.chan, got.chan);
          errors++;
        end
        if (got.value !== want.value) begin
          $error("result_value: expected %0d, got %0d", want.value, got.value);
          errors++;
        end
        if (got.last !== want.last) begin
          $error("last_channel: expected %0d, got %0d", want.last, got.last);
          errors++;
        end
      end
      out_stall = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    end
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
    end else if (out_stall != 0) begin
      out_stall--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni;
    end
  end

  // Watchdog on cycles without any accepted request, configuration write or result.
  always @(posedge clk_i) begin
    if (in_fire || out_fire || cfg_fire) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d cycles without progress.", idle_cycles);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Random Q8.8 value with a random magnitude, so small and full-scale values both occur.
  function automatic logic [15:0] rand_q88();
    logic signed [15:0] v;
    int unsigned        w;
    w = $urandom_range(1, 16);
    v = 16'($urandom);
    return v >>> (16 - w);
  endfunction

  task automatic push_req(logic [1:0] op, logic [3:0] oi, logic [3:0] ii, logic [15:0] val);
    conv_request_t req;
    req.op  = op;
    req.oi  = oi;
    req.ii  = ii;
    req.val = val;
    request_q.push_back(req);
    requests_queued++;
  endtask

  task automatic push_sample(logic [15:0] val);
    push_req(OP_SAMPLE, 4'($urandom), 4'($urandom), val);
  endtask

  // Mostly whole pixels with random content, plus store rewrites, ignored kinds and cut pixels.
  task automatic push_pixels(int unsigned n_items);
    int unsigned count, n_in, pick, cut;
    count = 0;
    n_in  = clip_reg(reg_mirror[REG_IN_CHANNELS], MaxInChannels);
    while (count < n_items) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        push_req(OP_WEIGHT, 4'($urandom), 4'($urandom), rand_q88());
      end else if (pick == 1) begin
        push_req(OP_BIAS, 4'($urandom), 4'($urandom), rand_q88());
      end else if (pick == 2) begin
        push_req(OP_IGNORED, 4'($urandom), 4'($urandom), 16'($urandom));
      end else begin
        cut = (pick == 3) ? $urandom_range(1, n_in) : n_in;
        for (int c = 0; c < cut; c++) push_sample(rand_q88());
        count += cut;
      end
    end
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx < NUM_REGS) reg_mirror[idx] = data & reg_mask(idx);
  endtask

  // Writes the whole register set back to back; the engine must be idle.
  task automatic program_regs(logic [15:0] ic, logic [15:0] oc, logic [15:0] fw,
                              logic [15:0] fh, logic [15:0] st, logic [15:0] amin,
                              logic [15:0] amax);
    cfg_write(REG_IN_CHANNELS, ic);
    cfg_write(REG_OUT_CHANNELS, oc);
    cfg_write(REG_FRAME_WIDTH, fw);
    cfg_write(REG_FRAME_HEIGHT, fh);
    cfg_write(REG_STRIDE, st);
    cfg_write(REG_ACT_MIN, amin);
    cfg_write(REG_ACT_MAX, amax);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // Waits until every request is taken and every result has come, then lets the engine settle.
  task automatic wait_idle();
    do @(posedge clk_i);
    while (requests_accepted != requests_queued || channel_results_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [15:0] lo, hi, tmp;
    reg_mirror = '{16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'h8000, 16'h7FFF};
    for (int i = 0; i < 16; i++) acc_mem[4'(i)] = 0;
    chan_cnt = 0;
    col_cnt  = 0;
    row_cnt  = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill every bias and the weights of the loaded input channels, so no sample reads
    // an unwritten entry.
    program_regs(16'd2, 16'd16, 16'd2, 16'd1, 16'd1, 16'h8000, 16'h7FFF);
    for (int oc = 0; oc < 16; oc++) begin
      push_req(OP_BIAS, 4'(oc), 4'($urandom), rand_q88());
      for (int ic = 0; ic < FILL_IN_CHANNELS; ic++) begin
        push_req(OP_WEIGHT, 4'(oc), 4'(ic), rand_q88());
      end
    end

    // Directed: full-scale saturation both ways, floor of a tiny negative sum, ignored kind.
    push_req(OP_BIAS, 4'd0, 4'd0, 16'h7FFF);
    push_req(OP_BIAS, 4'd1, 4'd15, 16'h8000);
    push_req(OP_BIAS, 4'd2, 4'd0, 16'h0000);
    push_req(OP_WEIGHT, 4'd0, 4'd0, 16'h7FFF);
    push_req(OP_WEIGHT, 4'd0, 4'd1, 16'h7FFF);
    push_req(OP_WEIGHT, 4'd1, 4'd0, 16'h8000);
    push_req(OP_WEIGHT, 4'd1, 4'd1, 16'h8000);
    push_req(OP_WEIGHT, 4'd2, 4'd0, 16'h0001);
    push_req(OP_WEIGHT, 4'd2, 4'd1, 16'h0000);
    push_req(OP_WEIGHT, 4'd15, 4'd15, 16'hFFFF);
    push_req(OP_IGNORED, 4'd15, 4'd15, 16'hFFFF);
    push_sample(16'hFFFF);
    push_sample(16'h7FFF);
    push_sample(16'h8000);
    push_req(OP_IGNORED, 4'd0, 4'd0, 16'h0000);
    push_sample(16'h8000);
    push_sample(16'h0000);
    push_sample(16'h0000);
    wait_idle();

    // Widest output count and frame, no idling; ends inside a pixel.
    no_gaps <= 1'b1;
    program_regs(16'(FILL_IN_CHANNELS), 16'd16, 16'd4096, 16'd4096, 16'd1, 16'h8000,
                 16'h7FFF);
    push_pixels(10);
    for (int c = 0; c < 3; c++) push_sample(rand_q88());
    wait_idle();

    // Counters now sit past the new limits; zero output count acts as one.
    no_gaps <= 1'b0;
    program_regs(16'd1, 16'd0, 16'd1, 16'd1, 16'd2, 16'h8000, 16'h7FFF);
    push_pixels(8);
    wait_idle();

    // Stride two with dropped pixels and a narrow clamp.
    program_regs(16'd3, 16'd5, 16'd5, 16'd3, 16'd2, 16'hFF00, 16'h0100);
    push_pixels(12);
    wait_idle();

    // Zero and oversized sizes, odd stride code, crossed clamps.
    program_regs(16'd0, 16'd31, 16'd0, 16'd8191, 16'd3, 16'h0064, 16'hFF9C);
    push_pixels(8);
    wait_idle();

    // Receiver holds off while single-channel pixels each produce sixteen results.
    no_gaps  <= 1'b1;
    hold_arm <= 1'b1;
    program_regs(16'd1, 16'd16, 16'd2, 16'd2, 16'd1, 16'h8000, 16'h7FFF);
    for (int p = 0; p < 12; p++) push_sample(rand_q88());
    wait_idle();
    no_gaps <= 1'b0;

    // Random small settings with ordered clamps.
    repeat (2) begin
      lo = 16'($urandom);
      hi = 16'($urandom);
      if ($signed(lo) > $signed(hi)) begin
        tmp = lo;
        lo  = hi;
        hi  = tmp;
      end
      program_regs(16'($urandom_range(1, FILL_IN_CHANNELS)), 16'($urandom_range(1, 16)),
                   16'($urandom_range(1, 6)), 16'($urandom_range(1, 4)),
                   16'($urandom_range(1, 2)), lo, hi);
      push_pixels(8);
      wait_idle();
    end

    // Raw random data on every register, including the unmapped index; the input count
    // keeps random upper bits but stays within the loaded weights.
    cfg_write(REG_UNUSED, 16'($urandom));
    program_regs({11'($urandom), 5'($urandom_range(0, FILL_IN_CHANNELS))}, 16'($urandom),
                 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom));
    push_pixels(8);
    wait_idle();

    $display("Covered %0d requests and %0d checked results over %0d register settings,",
             requests_accepted, results_seen, settings_used);
    $display("with saturation, stride drops, crossed clamps and a long receiver stall.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
